// ----- rtl/bdps_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bdps_pkg
// Shared constants and types for the block-diagonal pivot solve unit.
// ---------------------------------------------------------------------------
package bdps_pkg;

    localparam int DEF_FRAC_BITS  = 16;
    localparam int DEF_DATA_WIDTH = 32;
    localparam int PIV_WIDTH      = 17;
    localparam int ADDR_WIDTH     = 3;

    localparam logic [ADDR_WIDTH-1:0] REG_UPPER_STORAGE = 3'd0;

    typedef logic [1:0] status_t;
    localparam status_t STAT_OK   = 2'd0;
    localparam status_t STAT_DIVZ = 2'd1;
    localparam status_t STAT_SAT  = 2'd2;

    typedef enum logic [1:0] {
        MODE_PASS = 2'd0,
        MODE_ONE  = 2'd1,
        MODE_PAIR = 2'd2
    } mode_t;

endpackage

// ----- rtl/block_diag_pivot_solve_unit.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// block_diag_pivot_solve_unit
// Solves one 1x1 or 2x2 diagonal pivot block per request in fixed point,
// or passes the first right-hand side through.
// Takes one request per clock while the output is not stalled, and returns
// one result per request, in order. The Q16.16 default pipe has one input
// register, one multiply stage, one add/abs stage, one restoring divide
// stage per numerator bit (two dividers side by side sharing the
// determinant), and the output register. The whole pipe advances whenever
// the output register is empty or being taken, so s_ready follows m_ready.
module block_diag_pivot_solve_unit #(
    parameter int FRAC_BITS  = bdps_pkg::DEF_FRAC_BITS,
    parameter int DATA_WIDTH = bdps_pkg::DEF_DATA_WIDTH
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // config
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [bdps_pkg::ADDR_WIDTH-1:0]  paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    // requests
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic signed [bdps_pkg::PIV_WIDTH-1:0] s_pivot_this,
    input  logic signed [bdps_pkg::PIV_WIDTH-1:0] s_pivot_next,
    input  logic signed [DATA_WIDTH-1:0]     s_diag_first,
    input  logic signed [DATA_WIDTH-1:0]     s_diag_second,
    input  logic signed [DATA_WIDTH-1:0]     s_off_this,
    input  logic signed [DATA_WIDTH-1:0]     s_off_next,
    input  logic signed [DATA_WIDTH-1:0]     s_rhs_first,
    input  logic signed [DATA_WIDTH-1:0]     s_rhs_second,
    input  logic                             s_last_item,
    // results
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [DATA_WIDTH-1:0]     m_sol_first,
    output logic signed [DATA_WIDTH-1:0]     m_sol_second,
    output logic                             m_pair_used,
    output logic [1:0]                       m_status,
    output logic                             m_last_out
);
    import bdps_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int PW = 2 * W + 1;      // signed sums of products
    localparam int DW = PW;             // divisor magnitude
    localparam int NW = PW + FRAC_BITS; // shifted numerator magnitude

    typedef struct packed {
        mode_t           mode;
        logic            zero;
        logic            neg1;
        logic            neg2;
        logic            last;
        logic [W-1:0]    rhs;
        logic [DW-1:0]   den;
    } side_t;

    // ---------------- config ----------------
    logic upper_reg;
    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == REG_UPPER_STORAGE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upper_reg <= 1'b1;
        end else if (cfg_wr) begin
            upper_reg <= pwdata[0];
        end
    end

    assign prdata = (paddr == REG_UPPER_STORAGE) ? {31'd0, upper_reg} : 32'd0;

    // ---------------- flow control ----------------
    logic en;
    logic v1_reg, v2_reg;
    logic vd_reg [0:NW];
    logic m_valid_reg;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;
    assign m_valid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int k = 0; k <= NW; k++) begin
                vd_reg[k] <= 1'b0;
            end
        end else if (en) begin
            v1_reg    <= s_valid;
            v2_reg    <= v1_reg;
            vd_reg[0] <= v2_reg;
            for (int k = 0; k < NW; k++) begin
                vd_reg[k+1] <= vd_reg[k];
            end
            m_valid_reg <= vd_reg[NW];
        end
    end

    // ---------------- stage 1: capture, pick off-diagonal, decode ----------------
    mode_t              mode1_reg;
    logic signed [W-1:0] a1_reg, d1_reg, b1_reg, r11_reg, r21_reg;
    logic               last1_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (s_pivot_this > 0) begin
                mode1_reg <= MODE_ONE;
            end else if (s_pivot_this == s_pivot_next) begin
                mode1_reg <= MODE_PAIR;
            end else begin
                mode1_reg <= MODE_PASS;
            end
            a1_reg    <= s_diag_first;
            d1_reg    <= s_diag_second;
            b1_reg    <= upper_reg ? s_off_next : s_off_this;
            r11_reg   <= s_rhs_first;
            r21_reg   <= s_rhs_second;
            last1_reg <= s_last_item;
        end
    end

    // ---------------- stage 2: products ----------------
    mode_t                 mode2_reg;
    logic signed [2*W-1:0] ad_reg, bb_reg, dr1_reg, br2_reg, ar2_reg, br1_reg;
    logic signed [W-1:0]   a2_reg, r12_reg;
    logic                  last2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            mode2_reg <= mode1_reg;
            ad_reg    <= a1_reg * d1_reg;
            bb_reg    <= b1_reg * b1_reg;
            dr1_reg   <= d1_reg * r11_reg;
            br2_reg   <= b1_reg * r21_reg;
            ar2_reg   <= a1_reg * r21_reg;
            br1_reg   <= b1_reg * r11_reg;
            a2_reg    <= a1_reg;
            r12_reg   <= r11_reg;
            last2_reg <= last1_reg;
        end
    end

    // ---------------- stage 3: sums, magnitudes ----------------
    logic signed [PW-1:0] den_s, n1_s, n2_s;
    logic [PW-1:0]        den_m, n1_m, n2_m;

    always_comb begin
        if (mode2_reg == MODE_ONE) begin
            den_s = PW'(a2_reg);
            n1_s  = PW'(r12_reg);
        end else begin
            den_s = PW'(ad_reg) - PW'(bb_reg);
            n1_s  = PW'(dr1_reg) - PW'(br2_reg);
        end
        n2_s  = PW'(ar2_reg) - PW'(br1_reg);
        den_m = den_s[PW-1] ? PW'(-den_s) : PW'(den_s);
        n1_m  = n1_s[PW-1] ? PW'(-n1_s) : PW'(n1_s);
        n2_m  = n2_s[PW-1] ? PW'(-n2_s) : PW'(n2_s);
    end

    // ---------------- divider pipe ----------------
    side_t          side_reg [0:NW];
    logic [NW-1:0]  num1_reg [0:NW];
    logic [NW-1:0]  num2_reg [0:NW];
    logic [DW-1:0]  rem1_reg [0:NW];
    logic [DW-1:0]  rem2_reg [0:NW];
    logic [W-1:0]   q1_reg   [0:NW];
    logic [W-1:0]   q2_reg   [0:NW];
    logic           ovf1_reg [0:NW];
    logic           ovf2_reg [0:NW];

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0].mode <= mode2_reg;
            side_reg[0].zero <= (den_s == '0);
            side_reg[0].neg1 <= n1_s[PW-1] ^ den_s[PW-1];
            side_reg[0].neg2 <= n2_s[PW-1] ^ den_s[PW-1];
            side_reg[0].last <= last2_reg;
            side_reg[0].rhs  <= r12_reg;
            side_reg[0].den  <= den_m;
            num1_reg[0]      <= {n1_m, {FRAC_BITS{1'b0}}};
            num2_reg[0]      <= {n2_m, {FRAC_BITS{1'b0}}};
            rem1_reg[0]      <= '0;
            rem2_reg[0]      <= '0;
            q1_reg[0]        <= '0;
            q2_reg[0]        <= '0;
            ovf1_reg[0]      <= 1'b0;
            ovf2_reg[0]      <= 1'b0;
        end
    end

    for (genvar k = 0; k < NW; k++) begin : g_div
        logic [DW:0]   sh1, sh2;
        logic [DW+1:0] df1, df2;
        logic          ge1, ge2;

        always_comb begin
            sh1 = {rem1_reg[k], num1_reg[k][NW-1]};
            sh2 = {rem2_reg[k], num2_reg[k][NW-1]};
            df1 = {1'b0, sh1} - {2'b00, side_reg[k].den};
            df2 = {1'b0, sh2} - {2'b00, side_reg[k].den};
            ge1 = !df1[DW+1];
            ge2 = !df2[DW+1];
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[k+1] <= side_reg[k];
                num1_reg[k+1] <= {num1_reg[k][NW-2:0], 1'b0};
                num2_reg[k+1] <= {num2_reg[k][NW-2:0], 1'b0};
                rem1_reg[k+1] <= ge1 ? df1[DW-1:0] : sh1[DW-1:0];
                rem2_reg[k+1] <= ge2 ? df2[DW-1:0] : sh2[DW-1:0];
                q1_reg[k+1]   <= {q1_reg[k][W-2:0], ge1};
                q2_reg[k+1]   <= {q2_reg[k][W-2:0], ge2};
                // quotient bits pushed past the top mean the result overflows
                ovf1_reg[k+1] <= ovf1_reg[k] | q1_reg[k][W-1];
                ovf2_reg[k+1] <= ovf2_reg[k] | q2_reg[k][W-1];
            end
        end
    end

    // ---------------- output: sign, saturate, select ----------------
    side_t        so;
    logic [W-1:0] lim1, lim2, mag1, mag2, res1, res2;
    logic         sat1, sat2;
    logic [W-1:0] sol1_next, sol2_next;
    logic         pair_next;
    status_t      status_next;

    always_comb begin
        so   = side_reg[NW];
        lim1 = {1'b0, {(W-1){1'b1}}} + W'(so.neg1);
        lim2 = {1'b0, {(W-1){1'b1}}} + W'(so.neg2);
        sat1 = ovf1_reg[NW] || (q1_reg[NW] > lim1);
        sat2 = ovf2_reg[NW] || (q2_reg[NW] > lim2);
        mag1 = sat1 ? lim1 : q1_reg[NW];
        mag2 = sat2 ? lim2 : q2_reg[NW];
        res1 = so.neg1 ? W'(-mag1) : mag1;
        res2 = so.neg2 ? W'(-mag2) : mag2;

        sol1_next   = '0;
        sol2_next   = '0;
        pair_next   = 1'b0;
        status_next = STAT_OK;
        unique case (so.mode)
            MODE_ONE: begin
                if (so.zero) begin
                    status_next = STAT_DIVZ;
                end else begin
                    sol1_next = res1;
                    if (sat1) status_next = STAT_SAT;
                end
            end
            MODE_PAIR: begin
                pair_next = 1'b1;
                if (so.zero) begin
                    status_next = STAT_DIVZ;
                end else begin
                    sol1_next = res1;
                    sol2_next = res2;
                    if (sat1 || sat2) status_next = STAT_SAT;
                end
            end
            default: begin
                sol1_next = so.rhs;
            end
        endcase
    end

    logic [W-1:0] sol1_reg, sol2_reg;
    logic         pair_reg, last_reg;
    status_t      status_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            sol1_reg   <= sol1_next;
            sol2_reg   <= sol2_next;
            pair_reg   <= pair_next;
            status_reg <= status_next;
            last_reg   <= so.last;
        end
    end

    assign m_sol_first  = sol1_reg;
    assign m_sol_second = sol2_reg;
    assign m_pair_used  = pair_reg;
    assign m_status     = status_reg;
    assign m_last_out   = last_reg;

endmodule
